// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority ready queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 16;
	localparam int TAG_BITS  = 8;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam int CMD_W       = 2;
	localparam int IN_TAG_W    = 8;
	localparam int IN_PRIO_W   = 16;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 5;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 32;

	localparam logic [PRIO_BITS-1:0] PRIO_MAX = {PRIO_BITS{1'b1}};

	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     by_prio;
		prio_t    prio;
		tag_t     tag;
	} cell_ctl_t;

endpackage

// File: src/stable_priority_ready_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_ready_queue_top
// Sorted ready queue of process tags built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Each transaction is one command (insert by priority, append at tail, remove
// head) and produces exactly one result, held in the output
// register. All cells compare against the broadcast priority at once and
// shift in the same cycle, so one command is taken every clock; the input
// stalls only while the output register holds an untaken result. Entries of
// equal priority leave in arrival order. There is no clearing pass after
// reset: only the fill count and the output valid flag are cleared.
module stable_priority_ready_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // proc_tag[7:0], prio[23:8], arrival_time[39:24]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // head_tag[7:0], head_prio[23:8], occupancy[28:24]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int D = spq_pkg::DEPTH;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_d;
	logic                      out_valid_q;
	spq_pkg::status_t          status_q;
	logic [7:0]                head_tag_q;
	logic [15:0]               head_prio_q;

	logic                      accept;
	spq_pkg::cmd_t             cmd;
	spq_pkg::tag_t             in_tag;
	spq_pkg::prio_t            in_prio;
	spq_pkg::prio_t            in_arr;
	logic                      full;
	logic                      empty;
	logic                      do_push;
	logic                      do_rem;
	spq_pkg::prio_t            tail_prio;
	spq_pkg::prio_t            app_prio;
	spq_pkg::cell_ctl_t        ctl;
	spq_pkg::status_t          status_d;

	logic [D-1:0]              valid;
	logic [D-1:0]              after;
	spq_pkg::prio_t            prio_v [D];
	spq_pkg::tag_t             tag_v  [D];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign cmd      = spq_pkg::cmd_t'(s_tuser);
	assign in_tag   = spq_pkg::TAG_BITS'(s_tdata[7:0]);
	assign in_prio  = spq_pkg::PRIO_BITS'(s_tdata[23:8]);
	assign in_arr   = spq_pkg::PRIO_BITS'(s_tdata[39:24]);
	assign full     = (count_q == spq_pkg::CNT_W'(D));
	assign empty    = (count_q == '0);

	always_comb begin
		tail_prio = '0;
		for (int i = 0; i < D; i++) begin
			if (valid[i] && ((i == D - 1) || !valid[(i + 1) % D])) begin
				tail_prio = tail_prio | prio_v[i];
			end
		end
	end

	always_comb begin
		if (empty) begin
			app_prio = in_arr;
		end else if (tail_prio == spq_pkg::PRIO_MAX) begin
			app_prio = spq_pkg::PRIO_MAX;
		end else begin
			app_prio = tail_prio + spq_pkg::PRIO_BITS'(1);
		end
	end

	always_comb begin
		do_push     = 1'b0;
		do_rem      = 1'b0;
		status_d    = spq_pkg::ST_OK;
		ctl.op      = spq_pkg::OP_HOLD;
		ctl.by_prio = (cmd == spq_pkg::CMD_INSERT);
		ctl.prio    = (cmd == spq_pkg::CMD_INSERT) ? in_prio : app_prio;
		ctl.tag     = in_tag;
		count_d     = count_q;
		unique case (cmd)
			spq_pkg::CMD_INSERT, spq_pkg::CMD_APPEND: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					do_push = accept;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				if (empty) begin
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					do_rem = accept;
				end
			end
			default: begin
			end
		endcase
		if (do_push) begin
			ctl.op  = spq_pkg::OP_PUSH;
			count_d = count_q + spq_pkg::CNT_W'(1);
		end else if (do_rem) begin
			ctl.op  = spq_pkg::OP_SHIFT;
			count_d = count_q - spq_pkg::CNT_W'(1);
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		localparam int L = (g == 0) ? 0 : g - 1;
		localparam int R = (g == D - 1) ? g : g + 1;

		assign valid[g] = (spq_pkg::CNT_W'(g) < count_q);

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (valid[g]),
			.left_after ((g == 0) ? 1'b0 : after[L]),
			.left_prio  (prio_v[L]),
			.left_tag   (tag_v[L]),
			.right_prio (prio_v[R]),
			.right_tag  (tag_v[R]),
			.after      (after[g]),
			.prio       (prio_v[g]),
			.tag        (tag_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			head_tag_q  <= do_rem ? 8'(tag_v[0]) : 8'd0;
			head_prio_q <= do_rem ? 16'(prio_v[0]) : 16'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'd0, spq_pkg::OCC_W'(count_q), head_prio_q, head_tag_q};

endmodule

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry, takes new data, its left or
// its right neighbor's entry according to the broadcast command.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic              valid,
	input  logic              left_after,
	input  spq_pkg::prio_t    left_prio,
	input  spq_pkg::tag_t     left_tag,
	input  spq_pkg::prio_t    right_prio,
	input  spq_pkg::tag_t     right_tag,
	output logic              after,
	output spq_pkg::prio_t    prio,
	output spq_pkg::tag_t     tag
);

	spq_pkg::prio_t prio_q;
	spq_pkg::tag_t  tag_q;

	assign after = !valid || (ctl.by_prio && (prio_q > ctl.prio));
	assign prio  = prio_q;
	assign tag   = tag_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			spq_pkg::OP_PUSH: begin
				if (after && !left_after) begin
					prio_q <= ctl.prio;
					tag_q  <= ctl.tag;
				end else if (after) begin
					prio_q <= left_prio;
					tag_q  <= left_tag;
				end
			end
			spq_pkg::OP_SHIFT: begin
				prio_q <= right_prio;
				tag_q  <= right_tag;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority ready queue, bound to the top.
// ----------------------------------------------------------------------------
module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction gave no result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spq_pkg::ST_EMPTY) |-> (m_tdata[28:0] == 29'd0))
		else $error("empty status with nonzero head or occupancy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spq_pkg::ST_FULL) |->
			(m_tdata[28:24] == spq_pkg::OCC_W'(spq_pkg::DEPTH)) && (m_tdata[23:0] == 24'd0))
		else $error("full status with wrong occupancy or head");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && s_tvalid && s_tready |=>
			(m_tdata[28:24] == $past(m_tdata[28:24]) + 5'd1) ||
			(m_tdata[28:24] == $past(m_tdata[28:24]) - 5'd1) ||
			(m_tdata[28:24] == $past(m_tdata[28:24])))
		else $error("occupancy moved by more than one");

endmodule

bind stable_priority_ready_queue_top spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
